FILE: rtl/core/wavhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
package wavhp_pkg;

  // Parse phase codes.
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_MAGIC     = 5'd1;
  localparam logic [4:0] PH_RIFF_SIZE = 5'd2;
  localparam logic [4:0] PH_WAVE_ID   = 5'd3;
  localparam logic [4:0] PH_FMT_ID    = 5'd4;
  localparam logic [4:0] PH_FMT_LEN   = 5'd5;
  localparam logic [4:0] PH_FORMAT    = 5'd6;
  localparam logic [4:0] PH_CHANNELS  = 5'd7;
  localparam logic [4:0] PH_RATE      = 5'd8;
  localparam logic [4:0] PH_BYTE_RATE = 5'd9;
  localparam logic [4:0] PH_ALIGN     = 5'd10;
  localparam logic [4:0] PH_BITS      = 5'd11;
  localparam logic [4:0] PH_SKIP      = 5'd12;
  localparam logic [4:0] PH_CHUNK_ID  = 5'd13;
  localparam logic [4:0] PH_DATA_LEN  = 5'd14;
  localparam logic [4:0] PH_OTHER_LEN = 5'd15;
  localparam logic [4:0] PH_DONE      = 5'd16;

  // Status codes reported on the result stream.
  localparam logic [3:0] ST_READY     = 4'd0;
  localparam logic [3:0] ST_NIST      = 4'd1;
  localparam logic [3:0] ST_RAW       = 4'd2;
  localparam logic [3:0] ST_NOT_WAVE  = 4'd3;
  localparam logic [3:0] ST_NO_FMT    = 4'd4;
  localparam logic [3:0] ST_NOT_PCM   = 4'd5;
  localparam logic [3:0] ST_NOT_MONO  = 4'd6;
  localparam logic [3:0] ST_NOT_16BIT = 4'd7;
  localparam logic [3:0] ST_TRUNC     = 4'd8;

  // Four-character tags as they appear once collected little-endian.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_NIST = 32'h5453_494E;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BASE_LEN = 32'd16;
  localparam logic [15:0] PCM_FORMAT   = 16'd1;
  localparam logic [15:0] MONO_CHANS   = 16'd1;
  localparam logic [15:0] BITS_16      = 16'd16;

  typedef struct packed {
    logic [4:0]  phase;
    logic [1:0]  idx;
    logic [31:0] shift;
    logic [31:0] fmt_len;
    logic [31:0] skip;
    logic [31:0] rate;
  } wavhp_state_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] wav_rate;
    logic        rate_mismatch;
  } wavhp_result_t;

endpackage

FILE: rtl/core/wavhp_step.sv
// Next-state and verdict logic of the header parser for one byte.
module wavhp_step (
  input  wavhp_pkg::wavhp_state_t  st_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     first_byte_i,
  input  logic                     end_of_file_i,
  input  logic [31:0]              expected_rate_i,
  output wavhp_pkg::wavhp_state_t  st_o,
  output logic                     res_valid_o,
  output wavhp_pkg::wavhp_result_t res_o
);

  always_comb begin
    wavhp_pkg::wavhp_state_t cur;
    wavhp_pkg::wavhp_state_t nxt;
    logic        emit;
    logic        ready;
    logic [3:0]  code;
    logic        two_byte;
    logic        last;
    logic [31:0] v;
    logic [15:0] half;
    logic [31:0] extra;

    cur = st_i;
    if (first_byte_i) begin
      cur.phase   = wavhp_pkg::PH_MAGIC;
      cur.idx     = 2'd0;
      cur.shift   = '0;
      cur.fmt_len = '0;
      cur.skip    = '0;
      cur.rate    = '0;
    end
    nxt      = cur;
    emit     = 1'b0;
    ready    = 1'b0;
    code     = wavhp_pkg::ST_READY;
    two_byte = 1'b0;
    last     = 1'b0;
    v        = '0;
    half     = '0;
    extra    = '0;

    if (cur.phase != wavhp_pkg::PH_IDLE && cur.phase < wavhp_pkg::PH_DONE) begin
      if (cur.phase == wavhp_pkg::PH_SKIP) begin
        nxt.skip = cur.skip - 32'd1;
        if (nxt.skip == '0) begin
          nxt.phase = wavhp_pkg::PH_CHUNK_ID;
        end
      end else begin
        nxt.shift = {data_byte_i, cur.shift[31:8]};
        two_byte  = (cur.phase == wavhp_pkg::PH_FORMAT) ||
                    (cur.phase == wavhp_pkg::PH_CHANNELS) ||
                    (cur.phase == wavhp_pkg::PH_ALIGN) ||
                    (cur.phase == wavhp_pkg::PH_BITS);
        last      = two_byte ? (cur.idx != 2'd0) : (cur.idx == 2'd3);
        if (!last) begin
          nxt.idx = cur.idx + 2'd1;
        end else begin
          nxt.idx = 2'd0;
          v       = nxt.shift;
          half    = nxt.shift[31:16];
          unique case (cur.phase)
            wavhp_pkg::PH_MAGIC: begin
              if (v == wavhp_pkg::TAG_RIFF) begin
                nxt.phase = wavhp_pkg::PH_RIFF_SIZE;
              end else if (v == wavhp_pkg::TAG_NIST) begin
                emit = 1'b1;
                code = wavhp_pkg::ST_NIST;
              end else begin
                emit = 1'b1;
                code = wavhp_pkg::ST_RAW;
              end
            end
            wavhp_pkg::PH_RIFF_SIZE: nxt.phase = wavhp_pkg::PH_WAVE_ID;
            wavhp_pkg::PH_WAVE_ID: begin
              if (v != wavhp_pkg::TAG_WAVE) begin
                emit = 1'b1;
                code = wavhp_pkg::ST_NOT_WAVE;
              end else begin
                nxt.phase = wavhp_pkg::PH_FMT_ID;
              end
            end
            wavhp_pkg::PH_FMT_ID: begin
              if (v != wavhp_pkg::TAG_FMT) begin
                emit = 1'b1;
                code = wavhp_pkg::ST_NO_FMT;
              end else begin
                nxt.phase = wavhp_pkg::PH_FMT_LEN;
              end
            end
            wavhp_pkg::PH_FMT_LEN: begin
              nxt.fmt_len = v;
              nxt.phase   = wavhp_pkg::PH_FORMAT;
            end
            wavhp_pkg::PH_FORMAT: begin
              if (half != wavhp_pkg::PCM_FORMAT) begin
                emit = 1'b1;
                code = wavhp_pkg::ST_NOT_PCM;
              end else begin
                nxt.phase = wavhp_pkg::PH_CHANNELS;
              end
            end
            wavhp_pkg::PH_CHANNELS: begin
              if (half != wavhp_pkg::MONO_CHANS) begin
                emit = 1'b1;
                code = wavhp_pkg::ST_NOT_MONO;
              end else begin
                nxt.phase = wavhp_pkg::PH_RATE;
              end
            end
            wavhp_pkg::PH_RATE: begin
              nxt.rate  = v;
              nxt.phase = wavhp_pkg::PH_BYTE_RATE;
            end
            wavhp_pkg::PH_BYTE_RATE: nxt.phase = wavhp_pkg::PH_ALIGN;
            wavhp_pkg::PH_ALIGN:     nxt.phase = wavhp_pkg::PH_BITS;
            wavhp_pkg::PH_BITS: begin
              if (half != wavhp_pkg::BITS_16) begin
                emit = 1'b1;
                code = wavhp_pkg::ST_NOT_16BIT;
              end else begin
                extra = (cur.fmt_len > wavhp_pkg::FMT_BASE_LEN) ?
                        (cur.fmt_len - wavhp_pkg::FMT_BASE_LEN) : '0;
                nxt.skip  = extra;
                nxt.phase = (extra == '0) ? wavhp_pkg::PH_CHUNK_ID : wavhp_pkg::PH_SKIP;
              end
            end
            wavhp_pkg::PH_CHUNK_ID: begin
              nxt.phase = (v == wavhp_pkg::TAG_DATA) ? wavhp_pkg::PH_DATA_LEN :
                                                       wavhp_pkg::PH_OTHER_LEN;
            end
            wavhp_pkg::PH_DATA_LEN: begin
              emit  = 1'b1;
              ready = 1'b1;
              code  = wavhp_pkg::ST_READY;
            end
            wavhp_pkg::PH_OTHER_LEN: begin
              nxt.skip  = v;
              nxt.phase = (v == '0) ? wavhp_pkg::PH_CHUNK_ID : wavhp_pkg::PH_SKIP;
            end
            default: nxt.phase = wavhp_pkg::PH_DONE;
          endcase
        end
      end
      // A byte that ends the file without giving a verdict means the header was cut short.
      if (!emit && end_of_file_i) begin
        emit = 1'b1;
        code = wavhp_pkg::ST_TRUNC;
      end
      if (emit) begin
        nxt.phase = wavhp_pkg::PH_DONE;
      end
    end

    st_o                = nxt;
    res_valid_o         = emit;
    res_o.status        = code;
    res_o.wav_rate      = ready ? cur.rate : '0;
    res_o.rate_mismatch = ready && (expected_rate_i != '0) && (expected_rate_i != cur.rate);
  end

endmodule

FILE: rtl/core/wav_header_parser_core.sv
// Top level of the RIFF/WAVE PCM header parser with its stream ports.
// A byte accepted into the input register goes through the parse step into the result register.
// Throughput: one byte per cycle while results drain, limited by the single parse step.
// The input register frees up whenever the result register is empty or being drained.
// Reset: rst_ni is asynchronous and active low; it clears both valid flags, the parser
// state and the configured rate, after which bytes are ignored until a first-byte beat.
module wav_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: the expected sample rate, zero accepts any rate.
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Input stream, one file byte per beat.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] first_byte
  input  logic        s_axis_tlast_i,   // end_of_file
  // Result stream, at most one beat per file.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [3:0] status, [35:4] wav_rate,
                                        // [36] rate_mismatch, [39:37] zero
);

  // Configured rate; the user must write it only while the parser is quiet; not enforced.
  logic [31:0] exp_rate_q;

  // Input register holding one byte beat.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_eof_q;

  // Parser state and the result register.
  wavhp_pkg::wavhp_state_t  st_q, st_d;
  wavhp_pkg::wavhp_result_t out_q, res_d;
  logic                     out_valid_q;
  logic                     res_valid_d;

  logic advance;
  logic s_fire;
  logic step_fire;

  // The parse step may run when the result register is empty or drains this cycle.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign step_fire       = in_valid_q && advance;

  wavhp_step u_step (
    .st_i            (st_q),
    .data_byte_i     (in_byte_q),
    .first_byte_i    (in_first_q),
    .end_of_file_i   (in_eof_q),
    .expected_rate_i (exp_rate_q),
    .st_o            (st_d),
    .res_valid_o     (res_valid_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_rate_q <= '0;
    end else if (cfg_we_i) begin
      exp_rate_q <= cfg_wdata_i;
    end
  end

  // Control: valid flags and parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: wavhp_pkg::PH_IDLE, idx: 2'd0, shift: '0, fmt_len: '0,
                       skip: '0, rate: '0};
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_fire) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        st_q        <= st_d;
        out_valid_q <= res_valid_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
      in_eof_q   <= s_axis_tlast_i;
    end
    if (step_fire && res_valid_d) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.rate_mismatch, out_q.wav_rate, out_q.status};

  // A verdict other than ready never carries a rate or a mismatch flag.
  a_non_ready_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != wavhp_pkg::ST_READY) |->
      (out_q.wav_rate == '0 && !out_q.rate_mismatch))
    else $error("non-ready verdict carries rate or mismatch");

  // Only the defined status codes ever leave the block.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status <= wavhp_pkg::ST_TRUNC))
    else $error("status code out of range");

  // A byte skip in progress always has bytes left to skip.
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == wavhp_pkg::PH_SKIP) |-> (st_q.skip != '0))
    else $error("skip phase with zero bytes remaining");

  // Once a first-byte beat is parsed, the parser never falls back to waiting.
  a_first_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && in_first_q) |=> (st_q.phase != wavhp_pkg::PH_IDLE))
    else $error("parser idle after a first byte");

  // A verdict always moves the parser into its done phase.
  a_verdict_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && res_valid_d) |=> (st_q.phase == wavhp_pkg::PH_DONE))
    else $error("verdict without entering done phase");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the RIFF/WAVE PCM header parser core.
module tb;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          RANDOM_BYTES   = 1000;
  localparam int          MAX_FILE_BYTES = 4096;
  localparam logic [31:0] BLOCK_ALIGN    = 32'd2;

  // One test file: the header fields as written, plus how it is cut and
  // what verdict it must give when that is obvious from the fields.
  typedef struct {
    bit                       set_cfg;
    logic [31:0]              cfg_val;
    int                       junk;
    logic [31:0]              magic;
    logic [31:0]              riff_size;
    logic [31:0]              wave_id;
    logic [31:0]              fmt_id;
    logic [31:0]              fmt_len;
    logic [15:0]              format;
    logic [15:0]              chans;
    logic [31:0]              rate;
    logic [15:0]              bits;
    int                       chunks;
    logic [31:0]              chunk_len;
    logic [31:0]              data_len;
    int                       tail;
    int                       cut;
    bit                       eof;
    bit                       typed;
    wavhp_pkg::wavhp_result_t want;
  } wav_file_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [31:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] data_byte
  logic        s_axis_tuser_i  = 1'b0; // [0] first_byte
  logic        s_axis_tlast_i  = 1'b0; // end_of_file
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;         // [3:0] status, [35:4] wav_rate,
                                       // [36] rate_mismatch, [39:37] zero

  wav_header_parser_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Shadow of the parser state, stepped once per accepted input beat.
  logic [4:0]  parse_ph  = wavhp_pkg::PH_IDLE;
  logic [1:0]  byte_pos  = '0;
  logic [31:0] shift_acc = '0;
  logic [31:0] fmt_bytes = '0;
  logic [31:0] skip_left = '0;
  logic [31:0] file_rate = '0;
  logic [31:0] cfg_rate  = '0;

  wavhp_pkg::wavhp_result_t verdicts_due[$];
  logic [7:0]               file_bytes[$];
  int                       byte_cap;
  int                       bytes_sent  = 0;
  int                       mismatches  = 0;
  int                       idle_cycles = 0;
  bit                       gaps_on     = 1'b1;

  function automatic int field_bytes(input logic [4:0] ph);
    return (ph == wavhp_pkg::PH_FORMAT || ph == wavhp_pkg::PH_CHANNELS ||
            ph == wavhp_pkg::PH_ALIGN || ph == wavhp_pkg::PH_BITS) ? 2 : 4;
  endfunction

  function automatic wavhp_pkg::wavhp_result_t verdict_of(input logic [3:0] st,
                                                          input logic [31:0] rate,
                                                          input logic mis);
    wavhp_pkg::wavhp_result_t r;
    r.status        = st;
    r.wav_rate      = rate;
    r.rate_mismatch = mis;
    return r;
  endfunction

  // A zero-length skip goes straight on to the next chunk id.
  task automatic start_skip(input logic [31:0] n);
    skip_left = n;
    parse_ph  = (n == 0) ? wavhp_pkg::PH_CHUNK_ID : wavhp_pkg::PH_SKIP;
  endtask

  // Advances the shadow parser by one byte and reports the verdict it gives, if any.
  task automatic parse_header_byte(input logic [7:0] b, input logic first, input logic eof,
                                   output bit got, output wavhp_pkg::wavhp_result_t res);
    logic [31:0] v;
    logic [15:0] half;
    logic [3:0]  st;
    bit          has_st;
    got    = 1'b0;
    res    = '0;
    has_st = 1'b0;
    st     = wavhp_pkg::ST_READY;
    if (first) begin
      parse_ph  = wavhp_pkg::PH_MAGIC;
      byte_pos  = '0;
      shift_acc = '0;
      fmt_bytes = '0;
      skip_left = '0;
      file_rate = '0;
    end
    // Bytes before any file start, or after a verdict, are dropped silently.
    if (parse_ph != wavhp_pkg::PH_IDLE && parse_ph < wavhp_pkg::PH_DONE) begin
      if (parse_ph == wavhp_pkg::PH_SKIP) begin
        skip_left = skip_left - 1;
        if (skip_left == 0) parse_ph = wavhp_pkg::PH_CHUNK_ID;
      end else begin
        // Bytes enter at the top, so a finished field reads little-endian.
        shift_acc = {b, shift_acc[31:8]};
        if (int'(byte_pos) + 1 < field_bytes(parse_ph)) begin
          byte_pos = byte_pos + 2'd1;
        end else begin
          byte_pos = '0;
          v        = shift_acc;
          half     = shift_acc[31:16];
          case (parse_ph)
            wavhp_pkg::PH_MAGIC: begin
              if (v == wavhp_pkg::TAG_RIFF) parse_ph = wavhp_pkg::PH_RIFF_SIZE;
              else begin
                has_st = 1'b1;
                st     = (v == wavhp_pkg::TAG_NIST) ? wavhp_pkg::ST_NIST : wavhp_pkg::ST_RAW;
              end
            end
            wavhp_pkg::PH_RIFF_SIZE: parse_ph = wavhp_pkg::PH_WAVE_ID;
            wavhp_pkg::PH_WAVE_ID: begin
              if (v != wavhp_pkg::TAG_WAVE) begin
                has_st = 1'b1;
                st     = wavhp_pkg::ST_NOT_WAVE;
              end else parse_ph = wavhp_pkg::PH_FMT_ID;
            end
            wavhp_pkg::PH_FMT_ID: begin
              if (v != wavhp_pkg::TAG_FMT) begin
                has_st = 1'b1;
                st     = wavhp_pkg::ST_NO_FMT;
              end else parse_ph = wavhp_pkg::PH_FMT_LEN;
            end
            wavhp_pkg::PH_FMT_LEN: begin
              fmt_bytes = v;
              parse_ph  = wavhp_pkg::PH_FORMAT;
            end
            wavhp_pkg::PH_FORMAT: begin
              if (half != wavhp_pkg::PCM_FORMAT) begin
                has_st = 1'b1;
                st     = wavhp_pkg::ST_NOT_PCM;
              end else parse_ph = wavhp_pkg::PH_CHANNELS;
            end
            wavhp_pkg::PH_CHANNELS: begin
              if (half != wavhp_pkg::MONO_CHANS) begin
                has_st = 1'b1;
                st     = wavhp_pkg::ST_NOT_MONO;
              end else parse_ph = wavhp_pkg::PH_RATE;
            end
            wavhp_pkg::PH_RATE: begin
              file_rate = v;
              parse_ph  = wavhp_pkg::PH_BYTE_RATE;
            end
            wavhp_pkg::PH_BYTE_RATE: parse_ph = wavhp_pkg::PH_ALIGN;
            wavhp_pkg::PH_ALIGN:     parse_ph = wavhp_pkg::PH_BITS;
            wavhp_pkg::PH_BITS: begin
              if (half != wavhp_pkg::BITS_16) begin
                has_st = 1'b1;
                st     = wavhp_pkg::ST_NOT_16BIT;
              end else begin
                start_skip(fmt_bytes > wavhp_pkg::FMT_BASE_LEN ?
                           fmt_bytes - wavhp_pkg::FMT_BASE_LEN : '0);
              end
            end
            wavhp_pkg::PH_CHUNK_ID:
              parse_ph = (v == wavhp_pkg::TAG_DATA) ? wavhp_pkg::PH_DATA_LEN :
                                                      wavhp_pkg::PH_OTHER_LEN;
            wavhp_pkg::PH_DATA_LEN: begin
              has_st = 1'b1;
              st     = wavhp_pkg::ST_READY;
            end
            wavhp_pkg::PH_OTHER_LEN: start_skip(v);
            default:                 parse_ph = wavhp_pkg::PH_DONE;
          endcase
        end
      end
      // A verdict on the last byte wins over the early-end report.
      if (!has_st && eof) begin
        has_st = 1'b1;
        st     = wavhp_pkg::ST_TRUNC;
      end
      if (has_st) begin
        got      = 1'b1;
        res      = verdict_of(st, (st == wavhp_pkg::ST_READY) ? file_rate : '0,
                              st == wavhp_pkg::ST_READY && cfg_rate != 0 &&
                              cfg_rate != file_rate);
        parse_ph = wavhp_pkg::PH_DONE;
      end
    end
  endtask

  // File image helpers; anything past the cut is simply not emitted.
  task automatic put_le(input logic [31:0] v, input int n);
    int k;
    for (k = 0; k < n; k++)
      if (file_bytes.size() < byte_cap) file_bytes.push_back(v[8*k +: 8]);
  endtask

  task automatic put_fill(input logic [31:0] n);
    longint k;
    for (k = 0; k < longint'(n) && file_bytes.size() < byte_cap; k++)
      file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_file(input wav_file_t f);
    int c;
    byte_cap = (f.cut > 0) ? f.cut : MAX_FILE_BYTES;
    file_bytes.delete();
    put_le(f.magic, 4);
    put_le(f.riff_size, 4);
    put_le(f.wave_id, 4);
    put_le(f.fmt_id, 4);
    put_le(f.fmt_len, 4);
    put_le(32'(f.format), 2);
    put_le(32'(f.chans), 2);
    put_le(f.rate, 4);
    put_le({f.rate[30:0], 1'b0}, 4);
    put_le(BLOCK_ALIGN, 2);
    put_le(32'(f.bits), 2);
    if (f.fmt_len > wavhp_pkg::FMT_BASE_LEN) put_fill(f.fmt_len - wavhp_pkg::FMT_BASE_LEN);
    // Extra chunks carry a random id or one that is a single bit off "data".
    for (c = 0; c < f.chunks; c++) begin
      put_le($urandom_range(1) ? $urandom :
             wavhp_pkg::TAG_DATA ^ (32'h1 << $urandom_range(31)), 4);
      put_le(f.chunk_len, 4);
      put_fill(f.chunk_len);
    end
    put_le(wavhp_pkg::TAG_DATA, 4);
    put_le(f.data_len, 4);
    put_fill(f.tail);
  endtask

  function automatic wav_file_t good_wav(input logic [31:0] rate);
    wav_file_t f;
    f.set_cfg   = 1'b0;
    f.cfg_val   = '0;
    f.junk      = 0;
    f.magic     = wavhp_pkg::TAG_RIFF;
    f.riff_size = $urandom;
    f.wave_id   = wavhp_pkg::TAG_WAVE;
    f.fmt_id    = wavhp_pkg::TAG_FMT;
    f.fmt_len   = wavhp_pkg::FMT_BASE_LEN;
    f.format    = wavhp_pkg::PCM_FORMAT;
    f.chans     = wavhp_pkg::MONO_CHANS;
    f.rate      = rate;
    f.bits      = wavhp_pkg::BITS_16;
    f.chunks    = 0;
    f.chunk_len = '0;
    f.data_len  = $urandom;
    f.tail      = 2;
    f.cut       = 0;
    f.eof       = 1'b1;
    f.typed     = 1'b0;
    f.want      = '0;
    return f;
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(5))
      0:       return cfg_rate;
      1:       return 32'd8000;
      2:       return 32'd16000;
      3:       return 32'd44100;
      4:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rate_setting(input int k);
    case (k % 5)
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd16000;
      3:       return 32'd0;
      default: return 32'd44100;
    endcase
  endfunction

  // Mostly well-formed files so the deep phases get traffic; the rest break
  // one field, cut the file short, or abandon it without an end marker.
  function automatic wav_file_t random_file();
    wav_file_t f;
    int        pick;
    f    = good_wav(pick_rate());
    pick = $urandom_range(9);
    if (pick >= 8) f.fmt_len = $urandom_range(15);
    else if (pick >= 6) f.fmt_len = wavhp_pkg::FMT_BASE_LEN + $urandom_range(1, 6);
    f.chunks    = $urandom_range(2);
    f.chunk_len = $urandom_range(6);
    f.tail      = $urandom_range(3);
    f.junk      = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    pick        = $urandom_range(99);
    if (pick < 65) ;
    else if (pick < 70) f.magic = wavhp_pkg::TAG_NIST;
    else if (pick < 75) f.magic = $urandom;
    else if (pick < 79) f.wave_id = wavhp_pkg::TAG_WAVE ^ (32'h1 << $urandom_range(31));
    else if (pick < 83) f.fmt_id = wavhp_pkg::TAG_FMT ^ (32'h1 << $urandom_range(31));
    else if (pick < 86) f.format = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
    else if (pick < 89) f.chans = 16'($urandom_range(3));
    else if (pick < 92) begin
      f.bits = $urandom_range(1) ? 16'($urandom) :
               wavhp_pkg::BITS_16 ^ (16'h1 << $urandom_range(15));
    end
    else if (pick < 97) f.cut = $urandom_range(1, 50);
    else begin
      f.cut = $urandom_range(1, 40);
      f.eof = 1'b0;
    end
    return f;
  endfunction

  // Offers one byte, with random gaps, and steps the shadow parser once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic eof,
                           input bit typed, input wavhp_pkg::wavhp_result_t want);
    bit                       got;
    wavhp_pkg::wavhp_result_t res;
    while (gaps_on && $urandom_range(99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= first;
    s_axis_tlast_i  <= eof;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    parse_header_byte(b, first, eof, got, res);
    if (got) verdicts_due.push_back(typed ? want : res);
  endtask

  // Holds the sender back until every verdict is out and the pipe has emptied.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_rate     = v;
  endtask

  task automatic play_file(input wav_file_t f);
    int i;
    if (f.set_cfg) begin
      wait_drained();
      write_rate(f.cfg_val);
    end
    build_file(f);
    // Stray bytes without a file start, some of them marked as the end.
    for (i = 0; i < f.junk; i++)
      send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0, f.want);
    for (i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == 0, f.eof && (i == file_bytes.size() - 1), f.typed, f.want);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  // The result side stalls at random, except during the no-gap stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= !(gaps_on && $urandom_range(99) < 33);
  end

  // Every result beat is matched against the oldest pending verdict.
  always @(posedge clk_i) begin
    wavhp_pkg::wavhp_result_t seen;
    wavhp_pkg::wavhp_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen = verdict_of(m_axis_tdata_o[3:0], m_axis_tdata_o[35:4], m_axis_tdata_o[36]);
      if (verdicts_due.size() == 0) begin
        flag_mismatch("unrequested result, status", '0, seen.status);
      end else begin
        want = verdicts_due.pop_front();
        if (seen.status !== want.status) flag_mismatch("status", want.status, seen.status);
        if (seen.wav_rate !== want.wav_rate)
          flag_mismatch("wav_rate", want.wav_rate, seen.wav_rate);
        if (seen.rate_mismatch !== want.rate_mismatch)
          flag_mismatch("rate_mismatch", want.rate_mismatch, seen.rate_mismatch);
      end
    end
  end

  // A long run of cycles with no beat on either side means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wav_file_t plan[$];
    wav_file_t f;
    int        n;
    int        stop_at;

    // Directed files: at least one per status code plus the corner cases of the header walk.
    f = good_wav(32'd8000);
    f.junk = 3;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_READY, 32'd8000, 1'b0);
    plan.push_back(f);
    f = good_wav(32'd8000);
    f.magic = wavhp_pkg::TAG_NIST;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_NIST, '0, 1'b0);
    plan.push_back(f);
    f.magic = 32'h0000_0000;
    f.want = verdict_of(wavhp_pkg::ST_RAW, '0, 1'b0);
    plan.push_back(f);
    f.magic = 32'hFFFF_FFFF;
    plan.push_back(f);
    f = good_wav(32'd8000);
    f.wave_id = wavhp_pkg::TAG_WAVE ^ 32'h1;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_NOT_WAVE, '0, 1'b0);
    plan.push_back(f);
    f = good_wav(32'd8000);
    f.fmt_id = wavhp_pkg::TAG_DATA;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_NO_FMT, '0, 1'b0);
    plan.push_back(f);
    f = good_wav(32'd8000);
    f.format = 16'hFFFF;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_NOT_PCM, '0, 1'b0);
    plan.push_back(f);
    f = good_wav(32'd8000);
    f.chans = 16'd2;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_NOT_MONO, '0, 1'b0);
    plan.push_back(f);
    f = good_wav(32'd8000);
    f.bits = 16'd8;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_NOT_16BIT, '0, 1'b0);
    plan.push_back(f);
    // Files shorter than the magic, down to a single byte that both starts and ends.
    f = good_wav(32'd8000);
    f.cut = 3;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_TRUNC, '0, 1'b0);
    plan.push_back(f);
    f.cut = 1;
    plan.push_back(f);
    // Extra fmt bytes and zero-length chunks, then a short fmt length that skips nothing.
    f = good_wav(32'd44100);
    f.fmt_len = 32'd20;
    f.chunks = 2;
    plan.push_back(f);
    f = good_wav(32'd44100);
    f.fmt_len = 32'd14;
    f.chunks = 1;
    f.chunk_len = 32'd5;
    plan.push_back(f);
    // Skips far past the end of the file.
    f = good_wav(32'd8000);
    f.fmt_len = 32'hFFFF_FFFF;
    f.cut = 64;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_TRUNC, '0, 1'b0);
    plan.push_back(f);
    f.fmt_len = wavhp_pkg::FMT_BASE_LEN;
    f.chunks = 1;
    f.chunk_len = 32'hFFFF_FFFF;
    f.cut = 70;
    plan.push_back(f);
    f = good_wav(32'hFFFF_FFFF);
    f.data_len = 32'hFFFF_FFFF;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_READY, 32'hFFFF_FFFF, 1'b0);
    plan.push_back(f);
    f = good_wav(32'd0);
    f.data_len = 32'd0;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_READY, 32'd0, 1'b0);
    plan.push_back(f);
    // An abandoned file is restarted by the next file start.
    f = good_wav(32'd8000);
    f.cut = 30;
    f.eof = 1'b0;
    plan.push_back(f);
    plan.push_back(good_wav(32'd11025));
    // The ready verdict lands on the very last byte.
    f = good_wav(32'd22050);
    f.tail = 0;
    f.typed = 1'b1;
    f.want = verdict_of(wavhp_pkg::ST_READY, 32'd22050, 1'b0);
    plan.push_back(f);
    // Rate compare against a configured value, matching and not.
    f = good_wav(32'd16000);
    f.set_cfg = 1'b1;
    f.cfg_val = 32'd16000;
    plan.push_back(f);
    plan.push_back(good_wav(32'd16001));
    f = good_wav(32'hFFFF_FFFF);
    f.set_cfg = 1'b1;
    f.cfg_val = 32'hFFFF_FFFF;
    plan.push_back(f);
    plan.push_back(good_wav(32'd0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) play_file(plan[i]);

    // Random files, with a new rate setting every few files and one stretch
    // in which neither side idles.
    stop_at = bytes_sent + RANDOM_BYTES;
    for (n = 0; bytes_sent < stop_at; n++) begin
      f = random_file();
      if (n % 6 == 0) begin
        f.set_cfg = 1'b1;
        f.cfg_val = rate_setting(n / 6);
      end
      gaps_on = !(n >= 4 && n < 12);
      play_file(f);
    end
    gaps_on = 1'b1;

    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
